// ----- hw/rtl/cbns_pkg.sv -----
`timescale 1ns / 1ps

package cbns_pkg;

    // parser phase
    typedef enum logic [2:0] {
        PH_CODE    = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_NSID    = 3'd3,
        PH_SKIP    = 3'd4,
        PH_MATCHED = 3'd5,
        PH_DISCARD = 3'd6
    } t_phase;

    // result status codes
    typedef enum logic [1:0] {
        ST_FOUND      = 2'd0,
        ST_NO_MATCH   = 2'd1,
        ST_WRONG_CODE = 2'd2,
        ST_MALFORMED  = 2'd3
    } t_status;

    // configuration register indexes
    localparam logic CFG_WANTED_NAMESPACE = 1'b0;
    localparam logic CFG_REQUEST_CODE     = 1'b1;

    localparam int BYTE_W  = 8;
    localparam int FIELD_W = 16;

    typedef struct packed {
        t_status                    status;
        logic [FIELD_W-1:0]         offset;
        logic [FIELD_W-1:0]         length;
    } t_result;

endpackage

// ----- hw/rtl/cbns_parser.sv -----
`timescale 1ns / 1ps

module cbns_parser #(
    parameter int MAX_PACKET_BYTES = 65536
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [cbns_pkg::BYTE_W-1:0]   i_packet_byte,
    input  logic                          i_last_byte,
    input  logic [cbns_pkg::BYTE_W-1:0]   i_wanted_namespace,
    input  logic [cbns_pkg::BYTE_W-1:0]   i_request_code,
    output cbns_pkg::t_result             o_result
);

    // position saturates one past the limit
    localparam int PW = $clog2(MAX_PACKET_BYTES + 2);
    localparam int FW = cbns_pkg::FIELD_W;

    cbns_pkg::t_phase  r_phase, n_phase;
    logic [PW-1:0]     r_pos, n_pos;
    logic [FW-1:0]     r_record_size, n_record_size;
    logic [FW-1:0]     r_skip, n_skip;
    logic              r_match_seen, n_match_seen;
    logic [FW-1:0]     r_match_start, n_match_start;
    logic [FW-1:0]     r_match_size, n_match_size;
    logic              r_code_bad, n_code_bad;
    logic              nsid_final;
    logic [FW-1:0]     skip_dec;
    logic [PW:0]       pos_inc;
    cbns_pkg::t_status status;

    assign skip_dec = (r_skip != '0) ? r_skip - FW'(1) : r_skip;
    assign pos_inc  = {1'b0, r_pos} + (PW+1)'(1);

    always_comb begin
        n_phase       = r_phase;
        n_record_size = r_record_size;
        n_skip        = r_skip;
        n_match_seen  = r_match_seen;
        n_match_start = r_match_start;
        n_match_size  = r_match_size;
        n_code_bad    = r_code_bad;
        nsid_final    = 1'b0;
        case (r_phase)
            cbns_pkg::PH_CODE: begin
                n_code_bad = (i_packet_byte != i_request_code);
                n_phase    = n_code_bad ? cbns_pkg::PH_DISCARD : cbns_pkg::PH_LEN_HI;
            end
            cbns_pkg::PH_LEN_HI: begin
                n_record_size = {i_packet_byte, {cbns_pkg::BYTE_W{1'b0}}};
                n_phase       = cbns_pkg::PH_LEN_LO;
            end
            cbns_pkg::PH_LEN_LO: begin
                n_record_size = {r_record_size[FW-1:cbns_pkg::BYTE_W], i_packet_byte};
                n_phase       = cbns_pkg::PH_NSID;
            end
            cbns_pkg::PH_NSID: begin
                nsid_final = i_last_byte;
                if (i_packet_byte == i_wanted_namespace) begin
                    n_match_seen  = 1'b1;
                    n_match_start = FW'(pos_inc);
                    n_match_size  = r_record_size;
                    n_skip        = r_record_size;
                    n_phase       = cbns_pkg::PH_MATCHED;
                end else if (r_record_size == '0) begin
                    n_phase = cbns_pkg::PH_LEN_HI;
                end else begin
                    n_skip  = r_record_size;
                    n_phase = cbns_pkg::PH_SKIP;
                end
            end
            cbns_pkg::PH_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == '0) begin
                    n_phase = cbns_pkg::PH_LEN_HI;
                end
            end
            cbns_pkg::PH_MATCHED: begin
                n_skip = skip_dec;
            end
            default: begin
            end
        endcase
    end

    assign n_pos = (r_pos <= PW'(MAX_PACKET_BYTES)) ? PW'(pos_inc) : r_pos;

    // outcome in priority order
    always_comb begin
        if (n_code_bad) begin
            status = cbns_pkg::ST_WRONG_CODE;
        end else if (n_pos > PW'(MAX_PACKET_BYTES)) begin
            status = cbns_pkg::ST_MALFORMED;
        end else if (nsid_final) begin
            status = cbns_pkg::ST_NO_MATCH;
        end else if (n_phase == cbns_pkg::PH_MATCHED && n_match_seen) begin
            status = (n_skip != '0) ? cbns_pkg::ST_MALFORMED : cbns_pkg::ST_FOUND;
        end else if (n_phase == cbns_pkg::PH_SKIP && n_skip != '0) begin
            status = cbns_pkg::ST_MALFORMED;
        end else begin
            status = cbns_pkg::ST_NO_MATCH;
        end
        o_result.status = status;
        o_result.offset = (status == cbns_pkg::ST_FOUND) ? n_match_start : '0;
        o_result.length = (status == cbns_pkg::ST_FOUND) ? n_match_size : '0;
    end

    // state goes back to its reset value after each packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last_byte)) begin
            r_phase       <= cbns_pkg::PH_CODE;
            r_pos         <= '0;
            r_record_size <= '0;
            r_skip        <= '0;
            r_match_seen  <= 1'b0;
            r_match_start <= '0;
            r_match_size  <= '0;
            r_code_bad    <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_pos         <= n_pos;
            r_record_size <= n_record_size;
            r_skip        <= n_skip;
            r_match_seen  <= n_match_seen;
            r_match_start <= n_match_start;
            r_match_size  <= n_match_size;
            r_code_bad    <= n_code_bad;
        end
    end

endmodule

// ----- hw/rtl/channel_binding_nsid_scanner.sv -----
`timescale 1ns / 1ps

// channel-binding namespace scanner
// - input channel (i_in_valid / o_in_ready) takes one packet byte per transaction,
//   code byte first, with i_last_byte set on the final byte of the packet
// - output channel (o_out_valid / i_out_ready) gives exactly one result
//   transaction per packet, produced by its last byte: status, data offset
//   and data length of the first matching namespace record
// - config channel (i_cfg_valid / o_cfg_ready) writes wanted_namespace
//   (index 0) and request_code (index 1); it is always ready and should be
//   used only while no packet is in flight
// - o_out_valid rises once the last byte has been taken into the input register and then
//   passed into the result register; a full result register holds it in the input register
// - throughput: one byte per cycle; the input register feeds the parser and the
//   result register, and only a last byte waits for the result register
// - when the receiver stalls, one result sits in the result register and the next
//   packet keeps flowing until its last byte reaches the input register, then
//   o_in_ready drops
// - reset (synchronous, active low) empties both registers, returns the parser
//   to expecting a code byte and loads both config registers with 1
module channel_binding_nsid_scanner #(
    parameter int MAX_PACKET_BYTES = 65536
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // byte input
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [cbns_pkg::BYTE_W-1:0]         i_packet_byte,
    input  logic                                i_last_byte,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_scan_status,
    output logic [cbns_pkg::FIELD_W-1:0]        o_data_offset,
    output logic [cbns_pkg::FIELD_W-1:0]        o_data_length,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [cbns_pkg::BYTE_W-1:0]         i_cfg_data
);

    // config registers
    logic [cbns_pkg::BYTE_W-1:0] r_wanted_namespace;
    logic [cbns_pkg::BYTE_W-1:0] r_request_code;

    // input register
    logic                        r_in_valid;
    logic [cbns_pkg::BYTE_W-1:0] r_in_byte;
    logic                        r_in_last;

    // result register
    logic                        r_out_valid;
    cbns_pkg::t_result           r_out;

    logic              out_free;
    logic              advance;
    logic              in_take;
    cbns_pkg::t_result parse_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted_namespace <= cbns_pkg::BYTE_W'(1);
            r_request_code     <= cbns_pkg::BYTE_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cbns_pkg::CFG_WANTED_NAMESPACE: r_wanted_namespace <= i_cfg_data;
                cbns_pkg::CFG_REQUEST_CODE:     r_request_code     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // the result slot is free when empty or being drained this cycle
    assign out_free = !r_out_valid || i_out_ready;
    // a non-last byte never needs the result slot
    assign advance    = r_in_valid && (!r_in_last || out_free);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_packet_byte;
            r_in_last <= i_last_byte;
        end
    end

    cbns_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parser (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (advance),
        .i_packet_byte      (r_in_byte),
        .i_last_byte        (r_in_last),
        .i_wanted_namespace (r_wanted_namespace),
        .i_request_code     (r_request_code),
        .o_result           (parse_result)
    );

    // result register: loaded by the last byte of a packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= parse_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_scan_status = r_out.status;
    assign o_data_offset = r_out.offset;
    assign o_data_length = r_out.length;

    // back pressure only comes from a held byte
    a_ready_low_means_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid)
        else $error("input ready low with empty input register");

    // a processed last byte always shows up as a result
    a_last_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> o_out_valid)
        else $error("last byte did not load the result register");

    // offset and length are zero unless a record was found
    a_zero_unless_found : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_scan_status != cbns_pkg::ST_FOUND) |->
            (o_data_offset == '0 && o_data_length == '0))
        else $error("nonzero offset or length without a match");

    // a result only appears after a last byte was processed
    a_result_from_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(advance && r_in_last))
        else $error("result appeared without a last byte");

endmodule
